[hdl/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg - shared types and constants for the HSV to RGB converter
// Fixed-point scales, hue sector codes and the sector decode helpers.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_W  = 15;
	localparam int FRAC_W = 16;
	localparam int REM_W  = 12;
	localparam int DEN_W  = 28;

	// 360 degrees in 1/64 degree units, and one 60 degree sector
	localparam logic [HUE_W-1:0]  HUE_FULL   = 15'd23040;
	localparam logic [HUE_W-1:0]  HUE_SECTOR = 15'd3840;
	// unit fraction code and grey threshold on saturation
	localparam logic [FRAC_W-1:0] FRAC_ONE   = 16'd65535;
	localparam logic [FRAC_W-1:0] GREY_LIMIT = 16'd7;
	// FRAC_ONE * HUE_SECTOR, the common denominator of the y and z terms
	localparam logic [DEN_W-1:0]  TERM_DEN   = 28'd251654400;
	// ceil(2^24 / 15), exact floor division by 15 for 20-bit dividends
	localparam logic [20:0]       RECIP_15   = 21'd1118482;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} hue_sector_t;

	// hue already wrapped into 0..23039
	function automatic hue_sector_t sector_of(input logic [HUE_W-1:0] h);
		hue_sector_t sec;
		if (h >= 15'd19200) begin
			sec = SEC_MAG_RED;
		end else if (h >= 15'd15360) begin
			sec = SEC_BLU_MAG;
		end else if (h >= 15'd11520) begin
			sec = SEC_CYN_BLU;
		end else if (h >= 15'd7680) begin
			sec = SEC_GRN_CYN;
		end else if (h >= HUE_SECTOR) begin
			sec = SEC_YEL_GRN;
		end else begin
			sec = SEC_RED_YEL;
		end
		return sec;
	endfunction

	function automatic logic [HUE_W-1:0] sector_base(input hue_sector_t sec);
		logic [HUE_W-1:0] base;
		unique case (sec)
			SEC_RED_YEL: base = 15'd0;
			SEC_YEL_GRN: base = 15'd3840;
			SEC_GRN_CYN: base = 15'd7680;
			SEC_CYN_BLU: base = 15'd11520;
			SEC_BLU_MAG: base = 15'd15360;
			SEC_MAG_RED: base = 15'd19200;
			default:     base = 15'd0;
		endcase
		return base;
	endfunction

endpackage

[hdl/hsv_to_rgb_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core - pipelined HSV to RGB color conversion
// Seven-stage fixed-point hexcone conversion, one pixel per clock while out_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: hue (1/64 degree, 23040 = 360 deg, codes at or above wrap to
//   zero), saturation and brightness (Q0.16, 65535 = one). A beat is taken
//   when in_valid is high and in_stall is low.
//   Output beat: red, green, blue in the scale of brightness, taken when
//   out_valid is high and out_stall is low.
//   Throughput: one beat per clock while out_stall is low. The seven
//   register stages from input beat to out_valid are sector decode, two
//   multiply stages, two fold stages for /65535, a reciprocal multiply for
//   /15, and the sector routing into the output register.
//   Stall: every stage holds its beat while the next stage is full and
//   stalled; empty stages keep filling, so up to seven beats are absorbed
//   before in_stall rises. in_stall is combinational from out_stall.
//   Reset: arst_n clears all valid bits at once; no clearing pass.
//   Saturation below 7 gives grey, red = green = blue = brightness.
//   All terms truncate toward zero exactly, with no rounding error.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
	import hsv2rgb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [HUE_W-1:0]  hue,
	input  logic [FRAC_W-1:0] saturation,
	input  logic [FRAC_W-1:0] brightness,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [FRAC_W-1:0] red,
	output logic [FRAC_W-1:0] green,
	output logic [FRAC_W-1:0] blue
);

	// ---------------- handshake: per-stage valid and ready ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	// a stage takes a beat when it is empty or its beat moves on
	assign rdy_s7 = !vld_s7 || !out_stall;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
		end
	end

	// ---------------- stage 1: wrap hue, split into sector and remainder ----
	logic [HUE_W-1:0]  hue_wrap;
	hue_sector_t       sec_in;
	logic [HUE_W-1:0]  rem_wide;

	assign hue_wrap = (hue >= HUE_FULL) ? '0 : hue;
	assign sec_in   = sector_of(hue_wrap);
	assign rem_wide = hue_wrap - sector_base(sec_in);

	hue_sector_t       sec_s1;
	logic              grey_s1;
	logic [REM_W-1:0]  rem_s1;
	logic [FRAC_W-1:0] sat_s1;
	logic [FRAC_W-1:0] val_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			sec_s1  <= sec_in;
			grey_s1 <= (saturation < GREY_LIMIT);
			rem_s1  <= rem_wide[REM_W-1:0];
			sat_s1  <= saturation;
			val_s1  <= brightness;
		end
	end

	// ---------------- stage 2: numerators of the three terms ----------------
	// ny = D - s*rem, nz = D - s*(3840-rem), px = v*(65535-s)
	logic [DEN_W-1:0]   s_rem, s_crem;
	logic [REM_W-1:0]   crem;
	logic [FRAC_W-1:0]  s_inv;
	logic [2*FRAC_W-1:0] px_next;

	assign crem    = HUE_SECTOR[REM_W-1:0] - rem_s1;
	assign s_rem   = DEN_W'(sat_s1) * DEN_W'(rem_s1);
	assign s_crem  = DEN_W'(sat_s1) * DEN_W'(crem);
	assign s_inv   = FRAC_ONE - sat_s1;
	assign px_next = (2*FRAC_W)'(val_s1) * (2*FRAC_W)'(s_inv);

	hue_sector_t         sec_s2;
	logic                grey_s2;
	logic [FRAC_W-1:0]   val_s2;
	logic [DEN_W-1:0]    ny_s2, nz_s2;
	logic [2*FRAC_W-1:0] px_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			sec_s2  <= sec_s1;
			grey_s2 <= grey_s1;
			val_s2  <= val_s1;
			ny_s2   <= TERM_DEN - s_rem;
			nz_s2   <= TERM_DEN - s_crem;
			px_s2   <= px_next;
		end
	end

	// ---------------- stage 3: v times numerators; finish x -----------------
	localparam int PROD_W = FRAC_W + DEN_W;

	logic [PROD_W-1:0]  py_next, pz_next;
	logic [FRAC_W:0]    x_fold;
	logic [FRAC_W:0]    x_next;

	assign py_next = PROD_W'(val_s2) * PROD_W'(ny_s2);
	assign pz_next = PROD_W'(val_s2) * PROD_W'(nz_s2);
	// P/65535 = hi + (hi+lo)/65535, and hi+lo stays below 2*65535+1
	assign x_fold  = {1'b0, px_s2[2*FRAC_W-1:FRAC_W]} + {1'b0, px_s2[FRAC_W-1:0]};
	assign x_next  = {1'b0, px_s2[2*FRAC_W-1:FRAC_W]}
	               + (FRAC_W+1)'(x_fold >= 17'd65535)
	               + (FRAC_W+1)'(x_fold >= 17'd131070);

	hue_sector_t       sec_s3;
	logic              grey_s3;
	logic [FRAC_W-1:0] val_s3, x_s3;
	logic [PROD_W-1:0] py_s3, pz_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			sec_s3  <= sec_s2;
			grey_s3 <= grey_s2;
			val_s3  <= val_s2;
			x_s3    <= x_next[FRAC_W-1:0];
			py_s3   <= py_next;
			pz_s3   <= pz_next;
		end
	end

	// ---------------- stage 4: first fold of /65535 -------------------------
	localparam int HI_W = PROD_W - FRAC_W;

	hue_sector_t       sec_s4;
	logic              grey_s4;
	logic [FRAC_W-1:0] val_s4, x_s4;
	logic [HI_W-1:0]   ay_s4, az_s4;
	logic [HI_W:0]     ty_s4, tz_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			sec_s4  <= sec_s3;
			grey_s4 <= grey_s3;
			val_s4  <= val_s3;
			x_s4    <= x_s3;
			ay_s4   <= py_s3[PROD_W-1:FRAC_W];
			az_s4   <= pz_s3[PROD_W-1:FRAC_W];
			ty_s4   <= {1'b0, py_s3[PROD_W-1:FRAC_W]} + (HI_W+1)'(py_s3[FRAC_W-1:0]);
			tz_s4   <= {1'b0, pz_s3[PROD_W-1:FRAC_W]} + (HI_W+1)'(pz_s3[FRAC_W-1:0]);
		end
	end

	// ---------------- stage 5: second fold, q1 = floor(P/65535) -------------
	logic [FRAC_W:0] uy, uz;
	logic [HI_W-1:0] q1y_next, q1z_next;

	// t = c*65536 + d, and c + d stays below 2*65535
	assign uy = (FRAC_W+1)'(ty_s4[HI_W:FRAC_W]) + (FRAC_W+1)'(ty_s4[FRAC_W-1:0]);
	assign uz = (FRAC_W+1)'(tz_s4[HI_W:FRAC_W]) + (FRAC_W+1)'(tz_s4[FRAC_W-1:0]);
	assign q1y_next = ay_s4 + HI_W'(ty_s4[HI_W:FRAC_W]) + HI_W'(uy >= 17'd65535);
	assign q1z_next = az_s4 + HI_W'(tz_s4[HI_W:FRAC_W]) + HI_W'(uz >= 17'd65535);

	hue_sector_t       sec_s5;
	logic              grey_s5;
	logic [FRAC_W-1:0] val_s5, x_s5;
	logic [HI_W-1:0]   q1y_s5, q1z_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			sec_s5  <= sec_s4;
			grey_s5 <= grey_s4;
			val_s5  <= val_s4;
			x_s5    <= x_s4;
			q1y_s5  <= q1y_next;
			q1z_s5  <= q1z_next;
		end
	end

	// ---------------- stage 6: /3840 = drop 8 bits, then /15 by reciprocal --
	localparam int W_W   = HI_W - 8;
	localparam int REC_W = W_W + 21;

	logic [REC_W-1:0] ry, rz;

	assign ry = REC_W'(q1y_s5[HI_W-1:8]) * REC_W'(RECIP_15);
	assign rz = REC_W'(q1z_s5[HI_W-1:8]) * REC_W'(RECIP_15);

	hue_sector_t       sec_s6;
	logic              grey_s6;
	logic [FRAC_W-1:0] val_s6, x_s6, y_s6, z_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			sec_s6  <= sec_s5;
			grey_s6 <= grey_s5;
			val_s6  <= val_s5;
			x_s6    <= x_s5;
			y_s6    <= ry[24+FRAC_W-1:24];
			z_s6    <= rz[24+FRAC_W-1:24];
		end
	end

	// ---------------- stage 7: route terms by sector into output register ---
	logic [FRAC_W-1:0] r_next, g_next, b_next;

	always_comb begin
		if (grey_s6) begin
			r_next = val_s6;
			g_next = val_s6;
			b_next = val_s6;
		end else begin
			unique case (sec_s6)
				SEC_RED_YEL: begin
					r_next = val_s6; g_next = z_s6;   b_next = x_s6;
				end
				SEC_YEL_GRN: begin
					r_next = y_s6;   g_next = val_s6; b_next = x_s6;
				end
				SEC_GRN_CYN: begin
					r_next = x_s6;   g_next = val_s6; b_next = z_s6;
				end
				SEC_CYN_BLU: begin
					r_next = x_s6;   g_next = y_s6;   b_next = val_s6;
				end
				SEC_BLU_MAG: begin
					r_next = z_s6;   g_next = x_s6;   b_next = val_s6;
				end
				SEC_MAG_RED: begin
					r_next = val_s6; g_next = x_s6;   b_next = y_s6;
				end
				default: begin
					r_next = val_s6; g_next = x_s6;   b_next = y_s6;
				end
			endcase
		end
	end

	logic [FRAC_W-1:0] red_s7, green_s7, blue_s7;

	always_ff @(posedge clk) begin
		if (rdy_s7 && vld_s6) begin
			red_s7   <= r_next;
			green_s7 <= g_next;
			blue_s7  <= b_next;
		end
	end

	assign out_valid = vld_s7;
	assign red       = red_s7;
	assign green     = green_s7;
	assign blue      = blue_s7;

	// ---------------- assertions --------------------------------------------
	// an empty output slot means the whole ready chain is open
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output stage");

	// sector split leaves a remainder inside one sector
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (rem_s1 < HUE_SECTOR[REM_W-1:0]))
		else $error("hue remainder outside sector");

	// truncated terms never exceed brightness
	a_terms_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (x_s6 <= val_s6 && y_s6 <= val_s6 && z_s6 <= val_s6))
		else $error("color term above brightness");

endmodule
